// File: design/bcf_pkg.sv
// bcf_pkg: types and constants shared by the bootloader command framer.
// Item and result word layouts, phase and code enums, register map.
// No dependencies.
package bcf_pkg;

  localparam int unsigned MaxRes  = 5;
  localparam int unsigned ResCntW = 3;

  localparam logic [7:0] AckByte      = 8'h79;
  localparam logic [7:0] CodeSync     = 8'h7f;
  localparam logic [7:0] CodeGo       = 8'h21;
  localparam logic [7:0] CodeRead     = 8'h11;
  localparam logic [7:0] CodeWrite    = 8'h31;
  localparam logic [7:0] CodeErase    = 8'h43;
  localparam logic [7:0] CodeExtErase = 8'h44;
  localparam logic [7:0] ByteOnes     = 8'hff;
  localparam logic [7:0] ByteZero     = 8'h00;

  typedef enum logic [1:0] {
    OP_BEGIN   = 2'd0,
    OP_PAYLOAD = 2'd1,
    OP_RX      = 2'd2,
    OP_TICK    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CMD_SYNC  = 3'd0,
    CMD_GO    = 3'd1,
    CMD_READ  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_ERASE = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_BUSY     = 3'd0,
    ST_DONE     = 3'd1,
    ST_NACK     = 3'd2,
    ST_TIMEOUT  = 3'd3,
    ST_REJECTED = 3'd4
  } status_e;

  typedef enum logic [7:0] {
    PH_IDLE      = 8'b0000_0001,
    PH_SYNC_ACK  = 8'b0000_0010,
    PH_CMD_ACK   = 8'b0000_0100,
    PH_ADDR_ACK  = 8'b0000_1000,
    PH_LEN_ACK   = 8'b0001_0000,
    PH_READ      = 8'b0010_0000,
    PH_PAYLOAD   = 8'b0100_0000,
    PH_FINAL_ACK = 8'b1000_0000
  } phase_e;

  typedef enum logic [1:0] {
    REG_ACK_TIMEOUT   = 2'd0,
    REG_ERASE_TIMEOUT = 2'd1,
    REG_EXT_ERASE     = 2'd2
  } reg_e;

  localparam logic [15:0] AckTimeoutRst   = 16'd100;
  localparam logic [15:0] EraseTimeoutRst = 16'd2000;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  command;
    logic [31:0] address;
    logic [7:0]  count_minus_one;
    logic [7:0]  byte_value;
  } in_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [2:0] status;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [15:0] ack_timeout_ticks;
    logic [15:0] erase_timeout_ticks;
    logic        extended_erase;
  } cfg_t;

  typedef out_t [MaxRes-1:0] res_arr_t;

  function automatic logic [7:0] cmd_code(input logic [1:0] cmd);
    logic [7:0] code;
    case (cmd)
      2'd0:    code = CodeSync;
      2'd1:    code = CodeGo;
      2'd2:    code = CodeRead;
      default: code = CodeWrite;
    endcase
    return code;
  endfunction

  function automatic out_t tx_word(input logic [7:0] b);
    out_t w;
    w          = '0;
    w.tx_valid = 1'b1;
    w.tx_byte  = b;
    return w;
  endfunction

endpackage

// File: design/bcf_core.sv
// bcf_core: protocol state and the per-item step logic of the framer.
// Takes one item per accept, updates state, produces up to five result words.
// Depends on bcf_pkg.
module bcf_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bcf_pkg::cfg_t     cfg_i,
  input  logic              take_i,
  input  bcf_pkg::in_t      item_i,
  output bcf_pkg::res_arr_t res_o,
  output logic [bcf_pkg::ResCntW-1:0] res_cnt_o
);
  import bcf_pkg::*;

  phase_e      phase_q, phase_d;
  logic [2:0]  cmd_q, cmd_d;
  logic [31:0] addr_q, addr_d;
  logic [7:0]  count_q, count_d;
  logic [8:0]  idx_q, idx_d;
  logic [7:0]  xor_q, xor_d;
  logic [15:0] wait_q, wait_d;

  res_arr_t           res;
  logic [ResCntW-1:0] n;
  logic [2:0]         st;
  logic [7:0]         code;
  logic [7:0]         xor_n;
  logic [8:0]         idx_n;
  logic [8:0]         count_p1;
  logic [7:0]         addr_xor;
  logic [15:0]        wait_n;
  logic [15:0]        lim;
  logic [ResCntW-1:0] last_pos;

  assign count_p1 = {1'b0, count_q} + 9'd1;
  assign idx_n    = idx_q + 9'd1;
  assign xor_n    = xor_q ^ item_i.byte_value;
  assign addr_xor = addr_q[31:24] ^ addr_q[23:16] ^ addr_q[15:8] ^ addr_q[7:0];
  assign wait_n   = wait_q + 16'd1;
  assign lim      = (phase_q == PH_FINAL_ACK && cmd_q == CMD_ERASE)
                  ? cfg_i.erase_timeout_ticks : cfg_i.ack_timeout_ticks;

  always_comb begin
    phase_d  = phase_q;
    cmd_d    = cmd_q;
    addr_d   = addr_q;
    count_d  = count_q;
    idx_d    = idx_q;
    xor_d    = xor_q;
    wait_d   = wait_q;
    res      = '0;
    n        = '0;
    st       = ST_BUSY;
    code     = '0;
    last_pos = '0;

    case (item_i.op)
      OP_BEGIN: begin
        if (phase_q != PH_IDLE || item_i.command > CMD_ERASE) begin
          st = ST_REJECTED;
        end else begin
          cmd_d   = item_i.command;
          addr_d  = item_i.address;
          count_d = item_i.count_minus_one;
          idx_d   = '0;
          xor_d   = '0;
          wait_d  = '0;
          if (item_i.command == CMD_SYNC) begin
            res[0]  = tx_word(CodeSync);
            n       = 3'd1;
            phase_d = PH_SYNC_ACK;
          end else begin
            if (item_i.command == CMD_ERASE) begin
              code    = cfg_i.extended_erase ? CodeExtErase : CodeErase;
              // erase kind is latched here
              count_d = {7'd0, cfg_i.extended_erase};
            end else begin
              code = cmd_code(item_i.command[1:0]);
            end
            res[0]  = tx_word(code);
            res[1]  = tx_word(code ^ ByteOnes);
            n       = 3'd2;
            phase_d = PH_CMD_ACK;
          end
        end
      end
      OP_PAYLOAD: begin
        if (phase_q != PH_PAYLOAD) begin
          st = ST_REJECTED;
        end else begin
          res[0] = tx_word(item_i.byte_value);
          n      = 3'd1;
          xor_d  = xor_n;
          idx_d  = idx_n;
          if (idx_n == count_p1) begin
            res[1]  = tx_word(xor_n);
            n       = 3'd2;
            phase_d = PH_FINAL_ACK;
            wait_d  = '0;
          end
        end
      end
      OP_RX: begin
        if (phase_q == PH_IDLE || phase_q == PH_PAYLOAD) begin
          st = ST_REJECTED;
        end else if (phase_q == PH_READ) begin
          res[0].rx_valid = 1'b1;
          res[0].rx_byte  = item_i.byte_value;
          n               = 3'd1;
          wait_d          = '0;
          idx_d           = idx_n;
          if (idx_n == count_p1) begin
            st      = ST_DONE;
            phase_d = PH_IDLE;
          end
        end else if (item_i.byte_value != AckByte) begin
          st      = ST_NACK;
          phase_d = PH_IDLE;
          wait_d  = '0;
        end else begin
          wait_d = '0;
          case (phase_q)
            PH_SYNC_ACK, PH_FINAL_ACK: begin
              st      = ST_DONE;
              phase_d = PH_IDLE;
            end
            PH_CMD_ACK: begin
              if (cmd_q == CMD_ERASE) begin
                res[0] = tx_word(ByteOnes);
                if (count_q[0]) begin
                  res[1] = tx_word(ByteOnes);
                  res[2] = tx_word(ByteZero);
                  n      = 3'd3;
                end else begin
                  res[1] = tx_word(ByteZero);
                  n      = 3'd2;
                end
                phase_d = PH_FINAL_ACK;
              end else begin
                // address goes out big-endian, then its checksum
                res[0]  = tx_word(addr_q[31:24]);
                res[1]  = tx_word(addr_q[23:16]);
                res[2]  = tx_word(addr_q[15:8]);
                res[3]  = tx_word(addr_q[7:0]);
                res[4]  = tx_word(addr_xor);
                n       = 3'd5;
                phase_d = PH_ADDR_ACK;
              end
            end
            PH_ADDR_ACK: begin
              if (cmd_q == CMD_GO) begin
                st      = ST_DONE;
                phase_d = PH_IDLE;
              end else if (cmd_q == CMD_READ) begin
                res[0]  = tx_word(count_q);
                res[1]  = tx_word(count_q ^ ByteOnes);
                n       = 3'd2;
                phase_d = PH_LEN_ACK;
              end else begin
                res[0]  = tx_word(count_q);
                n       = 3'd1;
                xor_d   = count_q;
                idx_d   = '0;
                phase_d = PH_PAYLOAD;
              end
            end
            PH_LEN_ACK: begin
              idx_d   = '0;
              phase_d = PH_READ;
            end
            default: begin
              wait_d = wait_q;
            end
          endcase
        end
      end
      default: begin
        if (phase_q != PH_IDLE && phase_q != PH_PAYLOAD) begin
          wait_d = wait_n;
          if (wait_n >= lim) begin
            st      = ST_TIMEOUT;
            phase_d = PH_IDLE;
            wait_d  = '0;
          end
        end
      end
    endcase

    // every item yields at least one word; the final one carries the outcome
    if (n == '0) begin
      n = 3'd1;
    end
    last_pos             = n - 3'd1;
    res[last_pos].status = st;
    res[last_pos].last   = 1'b1;
  end

  assign res_o     = res;
  assign res_cnt_o = n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cmd_q   <= '0;
      addr_q  <= '0;
      count_q <= '0;
      idx_q   <= '0;
      xor_q   <= '0;
      wait_q  <= '0;
    end else if (take_i) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      addr_q  <= addr_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      xor_q   <= xor_d;
      wait_q  <= wait_d;
    end
  end

endmodule

// File: design/bcf_outbuf.sv
// bcf_outbuf: result register bank that holds the words of one item and
// hands them out one per output word. Depends on bcf_pkg.
module bcf_outbuf (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  bcf_pkg::res_arr_t           res_i,
  input  logic [bcf_pkg::ResCntW-1:0] res_cnt_i,
  output logic                        free_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output bcf_pkg::out_t               out_data_o
);
  import bcf_pkg::*;

  res_arr_t           words_q;
  logic [ResCntW-1:0] cnt_q;
  logic [ResCntW-1:0] idx_q;
  logic               pending;
  logic               is_last;
  logic               out_take;

  assign pending  = (cnt_q != '0);
  assign is_last  = (idx_q == cnt_q - 3'd1);
  assign out_take = pending && !out_stall_i;
  // the next item may enter in the cycle the last word leaves
  assign free_o   = !pending || (out_take && is_last);

  assign out_valid_o = pending;
  assign out_data_o  = words_q[idx_q];

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      words_q <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (load_i) begin
      cnt_q <= res_cnt_i;
      idx_q <= '0;
    end else if (out_take) begin
      if (is_last) begin
        cnt_q <= '0;
      end else begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

endmodule

// File: design/bootloader_command_framer_unit.sv
// bootloader_command_framer_unit: host-side framer for a UART bootloader.
// Holds the configuration registers; uses bcf_core, bcf_outbuf, bcf_pkg.
//
//   channel | direction | handshake             | word
//   in      | input     | in_valid_i/in_stall_o  | bcf_pkg::in_t
//   out     | output    | out_valid_o/out_stall_i| bcf_pkg::out_t
//   cfg     | input     | psel/penable/pwrite    | 32-bit register at 4*index
//
// an item is taken on a handshake and produces one to five result words
// the words leave one per cycle from the result bank while the output is not
// stalled; the next item enters as the last word leaves
// reset clears the phase, counters and result bank count; registers take their defaults
// a stalled output freezes the current word and holds off the input
module bootloader_command_framer_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bcf_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bcf_pkg::out_t out_data_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import bcf_pkg::*;

  cfg_t               cfg_q;
  logic               free;
  logic               take;
  logic               wr;
  res_arr_t           res;
  logic [ResCntW-1:0] res_cnt;

  assign pready     = 1'b1;
  assign wr         = psel && penable && pwrite && pready;
  assign in_stall_o = !free;
  assign take       = in_valid_i && free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ack_timeout_ticks   <= AckTimeoutRst;
      cfg_q.erase_timeout_ticks <= EraseTimeoutRst;
      cfg_q.extended_erase      <= 1'b0;
    end else if (wr) begin
      case (paddr[3:2])
        REG_ACK_TIMEOUT:   cfg_q.ack_timeout_ticks   <= pwdata[15:0];
        REG_ERASE_TIMEOUT: cfg_q.erase_timeout_ticks <= pwdata[15:0];
        REG_EXT_ERASE:     cfg_q.extended_erase      <= pwdata[0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ACK_TIMEOUT:   prdata = {16'd0, cfg_q.ack_timeout_ticks};
      REG_ERASE_TIMEOUT: prdata = {16'd0, cfg_q.erase_timeout_ticks};
      REG_EXT_ERASE:     prdata = {31'd0, cfg_q.extended_erase};
      default:           prdata = '0;
    endcase
  end

  bcf_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .take_i    (take),
    .item_i    (in_data_i),
    .res_o     (res),
    .res_cnt_o (res_cnt)
  );

  bcf_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .res_i       (res),
    .res_cnt_i   (res_cnt),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: design/bcf_checker.sv
// bcf_checker: port-level checks for the bootloader command framer,
// bound to bootloader_command_framer_unit. Depends on bcf_pkg.
module bcf_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input bcf_pkg::out_t out_data_o
);
  import bcf_pkg::*;

  // a held word does not change
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // every accepted item shows a word in the next cycle
  a_item_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted item produced no word");

  // input is only held off while words are waiting
  a_stall_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with nothing pending");

  // only the final word of an item carries an outcome
  a_mid_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> out_data_o.status == ST_BUSY)
    else $error("status on a non-final word");

endmodule

bind bootloader_command_framer_unit bcf_checker u_bcf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
